[rtl/atil_pkg.sv]
package atil_pkg;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    status_e            status;
    logic [DATA_W-1:0]  value_out;
  } res_t;

endpackage

[rtl/associative_table_insert_lookup_delete.sv]
// Key/value table of CAPACITY entries kept in arrival order in one synchronous
// RAM (key and value side by side). Read, write and delete scan the valid
// entries one per cycle through the RAM read port until a hit or the end of the
// valid entries; a delete hit then moves every later entry down one place, one
// per cycle. A clear sets entry_count to zero. A new request is accepted only
// once the controller has handed its last result on to the output register.
// The result waits in an output register while the next item is taken in.
// Entries past entry_count are never used, so the RAM needs no clearing after
// reset.
module associative_table_insert_lookup_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value_in[63:32]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // value_out[31:0], entry_count[38:32], zero[39]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  logic            res_valid;
  logic            res_ready;
  atil_pkg::res_t  res;
  atil_pkg::res_t  out_res;

  atil_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_req   (atil_pkg::req_e'(s_axis_tuser)),
    .in_key   (s_axis_tdata[31:0]),
    .in_value (s_axis_tdata[63:32]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.entry_count, out_res.value_out};
  assign m_axis_tuser = out_res.status;

endmodule

[rtl/atil_ram.sv]
module atil_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/atil_ctrl.sv]
module atil_ctrl #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  atil_pkg::req_e       in_req,
  input  logic [31:0]          in_key,
  input  logic [31:0]          in_value,
  output logic                 res_valid,
  input  logic                 res_ready,
  output atil_pkg::res_t       res
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t               state, state_next;
  atil_pkg::req_e       req, req_next;
  logic [31:0]          key, key_next;
  logic [31:0]          val, val_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CW-1:0]        pos, pos_next;
  logic                 pend, pend_next;
  logic [31:0]          res_value, res_value_next;
  atil_pkg::status_e    res_status, res_status_next;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  atil_pkg::entry_t     wdata;
  atil_pkg::entry_t     rdata;
  logic [$bits(atil_pkg::entry_t)-1:0] rdata_raw;
  logic                 hit;

  atil_ram #(
    .WIDTH($bits(atil_pkg::entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rdata     = atil_pkg::entry_t'(rdata_raw);
  assign hit       = pend && (rdata.key == key);
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.value_out   = res_value;
  assign res.status      = res_status;
  assign res.entry_count = atil_pkg::COUNT_W'(count);

  always_comb begin
    state_next      = state;
    req_next        = req;
    key_next        = key;
    val_next        = val;
    count_next      = count;
    idx_next        = idx;
    pos_next        = pos;
    pend_next       = 1'b0;
    res_value_next  = res_value;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = pos[AW-1:0];
    wdata           = '{value: val, key: key};
    raddr           = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next        = in_req;
          key_next        = in_key;
          val_next        = in_value;
          idx_next        = '0;
          res_value_next  = '0;
          res_status_next = atil_pkg::ST_DONE;
          if (in_req == atil_pkg::REQ_CLEAR) begin
            count_next = '0;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          unique case (req)
            atil_pkg::REQ_READ: begin
              res_value_next = rdata.value;
              state_next     = S_DONE;
            end
            atil_pkg::REQ_WRITE: begin
              we         = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              idx_next   = pos + 1'b1;
              pos_next   = pos;
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
          endcase
        end else if (idx == count) begin
          state_next = S_DONE;
          if (req == atil_pkg::REQ_WRITE) begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = atil_pkg::ST_FULL;
            end else begin
              we              = 1'b1;
              waddr           = count[AW-1:0];
              count_next      = count + 1'b1;
              res_status_next = atil_pkg::ST_INSERTED;
            end
          end else begin
            res_status_next = atil_pkg::ST_MISSING;
          end
        end else begin
          pend_next = 1'b1;
          pos_next  = idx;
          idx_next  = idx + 1'b1;
        end
      end
      S_SHIFT: begin
        if (pend) begin
          we       = 1'b1;
          wdata    = rdata;
          pos_next = pos + 1'b1;
        end
        if (idx < count) begin
          pend_next = 1'b1;
          idx_next  = idx + 1'b1;
        end else begin
          count_next = count - 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    key        <= key_next;
    val        <= val_next;
    idx        <= idx_next;
    pos        <= pos_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [atil_pkg::DATA_W-1:0]  value_out;
    atil_pkg::status_e            status;
    logic [atil_pkg::COUNT_W-1:0] entry_count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // key[31:0], value_in[63:32]
  logic [1:0]  s_axis_tuser = atil_pkg::REQ_READ;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // value_out[31:0], entry_count[38:32], zero[39]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  associative_table_insert_lookup_delete #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  logic [atil_pkg::DATA_W-1:0] shadow_keys   [CAPACITY];
  logic [atil_pkg::DATA_W-1:0] shadow_values [CAPACITY];
  int unsigned                 shadow_count = 0;

  table_result_t               pending_results [$];
  logic [atil_pkg::DATA_W-1:0] key_pool [128];
  int unsigned                 pool_size = 1;
  bit                          gaps_on = 1'b1;
  int unsigned                 error_count = 0;
  int unsigned                 cycle_count = 0;
  int unsigned                 sent_count [4] = '{default: 0};
  int unsigned                 status_count [4] = '{default: 0};

  function automatic int find_entry(logic [atil_pkg::DATA_W-1:0] k);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t apply_request(atil_pkg::req_e req,
                                                   logic [atil_pkg::DATA_W-1:0] k,
                                                   logic [atil_pkg::DATA_W-1:0] v);
    table_result_t r;
    int pos;
    r.value_out = '0;
    r.status    = atil_pkg::ST_DONE;
    pos = find_entry(k);
    case (req)
      atil_pkg::REQ_READ: begin
        if (pos >= 0) r.value_out = shadow_values[pos];
        else r.status = atil_pkg::ST_MISSING;
      end
      atil_pkg::REQ_WRITE: begin
        if (pos >= 0) begin
          shadow_values[pos] = v;
        end else if (shadow_count >= CAPACITY) begin
          r.status = atil_pkg::ST_FULL;
        end else begin
          shadow_keys[shadow_count]   = k;
          shadow_values[shadow_count] = v;
          shadow_count++;
          r.status = atil_pkg::ST_INSERTED;
        end
      end
      atil_pkg::REQ_DELETE: begin
        if (pos < 0) begin
          r.status = atil_pkg::ST_MISSING;
        end else begin
          for (int j = pos; j + 1 < shadow_count; j++) begin
            shadow_keys[j]   = shadow_keys[j + 1];
            shadow_values[j] = shadow_values[j + 1];
          end
          shadow_count--;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    r.entry_count = shadow_count[atil_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(atil_pkg::req_e req, logic [atil_pkg::DATA_W-1:0] k,
                              logic [atil_pkg::DATA_W-1:0] v);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_request(req, k, v));
    sent_count[req]++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [atil_pkg::DATA_W-1:0] absent_key();
    logic [atil_pkg::DATA_W-1:0] k;
    do k = $urandom; while (find_entry(k) >= 0);
    return k;
  endfunction

  task automatic test_basic_requests();
    send_request(atil_pkg::REQ_READ,   32'h0000_0001, 32'h1234_5678);   // empty table
    send_request(atil_pkg::REQ_DELETE, 32'h0000_0001, 32'h0);
    send_request(atil_pkg::REQ_WRITE,  32'h8000_0000, 32'h7fff_ffff);
    send_request(atil_pkg::REQ_WRITE,  32'h7fff_ffff, 32'h8000_0000);
    send_request(atil_pkg::REQ_WRITE,  32'h0000_0000, 32'hffff_ffff);
    send_request(atil_pkg::REQ_WRITE,  32'hffff_ffff, 32'h0000_0000);
    send_request(atil_pkg::REQ_READ,   32'h8000_0000, 32'h0);
    send_request(atil_pkg::REQ_READ,   32'h7fff_ffff, 32'h0);
    send_request(atil_pkg::REQ_READ,   32'h0000_0000, 32'h0);
    send_request(atil_pkg::REQ_READ,   32'hffff_ffff, 32'hffff_ffff);
    send_request(atil_pkg::REQ_WRITE,  32'h0000_0000, 32'h5a5a_a5a5);   // update
    send_request(atil_pkg::REQ_READ,   32'h0000_0000, 32'h0);
    send_request(atil_pkg::REQ_READ,   32'h0000_0002, 32'h0);           // miss
    send_request(atil_pkg::REQ_DELETE, 32'h7fff_ffff, 32'h0);           // middle entry
    send_request(atil_pkg::REQ_READ,   32'hffff_ffff, 32'h0);
    send_request(atil_pkg::REQ_DELETE, 32'h7fff_ffff, 32'h0);           // already gone
    send_request(atil_pkg::REQ_CLEAR,  32'hffff_ffff, 32'hffff_ffff);
    send_request(atil_pkg::REQ_READ,   32'h8000_0000, 32'h0);
    send_request(atil_pkg::REQ_CLEAR,  32'h0, 32'h0);                   // clear when empty
  endtask

  task automatic test_full_table();
    logic [atil_pkg::DATA_W-1:0] k;
    send_request(atil_pkg::REQ_CLEAR, $urandom, $urandom);
    for (int i = 0; i < CAPACITY; i++) begin
      send_request(atil_pkg::REQ_WRITE, absent_key(), $urandom);
    end
    send_request(atil_pkg::REQ_WRITE, absent_key(), $urandom);          // table full
    send_request(atil_pkg::REQ_WRITE, shadow_keys[CAPACITY-1], $urandom);
    send_request(atil_pkg::REQ_READ,  shadow_keys[CAPACITY-1], $urandom);
    send_request(atil_pkg::REQ_READ,  absent_key(), $urandom);
    send_request(atil_pkg::REQ_DELETE, shadow_keys[0], $urandom);       // longest shift
    send_request(atil_pkg::REQ_READ,  shadow_keys[shadow_count-1], $urandom);
    send_request(atil_pkg::REQ_WRITE, absent_key(), $urandom);
    k = absent_key();
    send_request(atil_pkg::REQ_WRITE, k, $urandom);
    send_request(atil_pkg::REQ_DELETE, shadow_keys[shadow_count-1], $urandom);
    send_request(atil_pkg::REQ_DELETE, absent_key(), $urandom);
    send_request(atil_pkg::REQ_CLEAR, $urandom, $urandom);
  endtask

  function automatic logic [atil_pkg::DATA_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned    roll;
    atil_pkg::req_e req;
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on   = (phase % 3 != 2);
      pool_size = $urandom_range(4, 100);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int i = 0; i < n_items / 8; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) req = atil_pkg::REQ_WRITE;
        else if (roll < 75) req = atil_pkg::REQ_READ;
        else if (roll < 97) req = atil_pkg::REQ_DELETE;
        else req = atil_pkg::REQ_CLEAR;
        send_request(req, pick_key(), $urandom);
      end
      if (phase % 2 == 1) wait_for_results();
    end
    gaps_on = 1'b1;
  endtask

  // result side: random stall before each item while gaps are on
  initial begin
    int unsigned stall;
    forever begin
      stall = gaps_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      status_count[m_axis_tuser]++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected item, expected none, actual value_out=%h status=%0d count=%0d",
                 $time, m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[38:32]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.value_out) begin
          error_count++;
          $display("%0t: value_out expected %h actual %h",
                   $time, want.value_out, m_axis_tdata[31:0]);
        end
        if (m_axis_tuser !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
        end
        if (m_axis_tdata[38:32] !== want.entry_count) begin
          error_count++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, m_axis_tdata[38:32]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_requests();
    wait_for_results();
    test_full_table();
    wait_for_results();
    test_random_traffic(800);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Requests: %0d read, %0d write, %0d delete, %0d clear",
             sent_count[atil_pkg::REQ_READ], sent_count[atil_pkg::REQ_WRITE],
             sent_count[atil_pkg::REQ_DELETE], sent_count[atil_pkg::REQ_CLEAR]);
    $display("Results: %0d done, %0d inserted, %0d not found, %0d full; %0d errors",
             status_count[atil_pkg::ST_DONE], status_count[atil_pkg::ST_INSERTED],
             status_count[atil_pkg::ST_MISSING], status_count[atil_pkg::ST_FULL],
             error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
